// ===== sv/ddo_pkg.sv =====
package ddo_pkg;

  // Default values of the top level parameters.
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int FRAC_BITS_DEF = 16;

  // Configuration register indexes.
  localparam logic [2:0] REG_WHEEL_RADIUS = 3'd0;
  localparam logic [2:0] REG_INV_WHEEL_BASE = 3'd1;
  localparam logic [2:0] REG_INIT_X = 3'd2;
  localparam logic [2:0] REG_INIT_Y = 3'd3;
  localparam logic [2:0] REG_INIT_HEADING = 3'd4;

  // Item commands.
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  // Internal widths.
  localparam int MID_W = 45;   // mid-step heading magnitude
  localparam int REM_W = 28;   // remainder modulo two pi
  localparam int CW = 34;      // CORDIC datapath
  localparam int QUEUE_DEPTH = 2;

  // Pi in Q2.62, and the Q2.30 constants of the CORDIC.
  localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;
  localparam logic signed [CW-1:0] PI_Q30 = 34'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;

  // Configuration register file contents.
  typedef struct packed {
    logic [15:0] wheel_radius;
    logic [23:0] inv_wheel_base;
    logic signed [31:0] init_x;
    logic signed [31:0] init_y;
    logic signed [31:0] init_heading;
  } cfg_t;

  // One queued item: command and the wheel angle changes.
  typedef struct packed {
    logic cmd;
    logic signed [32:0] delta_left;
    logic signed [32:0] delta_right;
  } item_t;

  // Arctangent of 2^-i in Q2.30.
  function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [CW-1:0] v;
    case (idx)
      5'd0: v = 34'sd843314857;
      5'd1: v = 34'sd497837829;
      5'd2: v = 34'sd263043837;
      5'd3: v = 34'sd133525159;
      5'd4: v = 34'sd67021687;
      5'd5: v = 34'sd33543516;
      5'd6: v = 34'sd16775851;
      5'd7: v = 34'sd8388437;
      5'd8: v = 34'sd4194283;
      5'd9: v = 34'sd2097149;
      5'd10: v = 34'sd1048576;
      5'd11: v = 34'sd524288;
      5'd12: v = 34'sd262144;
      5'd13: v = 34'sd131072;
      5'd14: v = 34'sd65536;
      5'd15: v = 34'sd32768;
      5'd16: v = 34'sd16384;
      5'd17: v = 34'sd8192;
      5'd18: v = 34'sd4096;
      5'd19: v = 34'sd2048;
      5'd20: v = 34'sd1024;
      5'd21: v = 34'sd512;
      5'd22: v = 34'sd256;
      5'd23: v = 34'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Clamp a wide signed value to the 32-bit signed range.
  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > 72'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -72'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/ddo_in_if.sv =====
interface ddo_in_if;
  logic valid;
  logic ready;
  logic cmd;
  logic signed [31:0] angle_left;
  logic signed [31:0] angle_right;

  modport source (output valid, output cmd, output angle_left, output angle_right,
                  input ready);
  modport sink (input valid, input cmd, input angle_left, input angle_right,
                output ready);
endinterface

// ===== sv/ddo_out_if.sv =====
interface ddo_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] heading;
  logic signed [31:0] distance_step;

  modport source (output valid, output pos_x, output pos_y, output heading,
                  output distance_step, input ready);
  modport sink (input valid, input pos_x, input pos_y, input heading,
                input distance_step, output ready);
endinterface

// ===== sv/diff_drive_odometry.sv =====
// Differential-drive wheel odometry.
// Items arrive on the items channel (valid/ready): cmd selects an odometry
// update or a reload of the pose from the init registers; both carry the
// absolute left and right wheel angles, and the block keeps the previous ones.
// Each item gives exactly one transaction on the results channel with the
// pose after the item and the forward step.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data), to be
// written only while no item is in flight.
// An update runs the wheel arcs and the heading change on one shared
// multiplier, a reduction of the mid-step heading modulo two pi by
// reciprocal multiplication, one CORDIC rotation per cycle, and then the
// x and y products on the same multiplier: five products in all. The back
// end finishes each item, load or update, before it takes the next.
// A two-entry queue after the input lets items be taken while the back end
// works; a full result register stalling on results.ready holds the back end,
// and once the queue fills, items.ready drops.
// Synchronous reset clears the pose, the stored angles and the queue, and
// loads the register reset values.
module diff_drive_odometry
  import ddo_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  ddo_in_if.sink      items,
  ddo_out_if.source   results,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t cfg;
  logic q_full;
  logic q_push;
  item_t q_in;
  logic q_pop;
  logic q_avail;
  item_t q_out;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wheel_radius <= 16'd2621;
      cfg.inv_wheel_base <= 24'd327680;
      cfg.init_x <= '0;
      cfg.init_y <= '0;
      cfg.init_heading <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WHEEL_RADIUS: cfg.wheel_radius <= cfg_data[15:0];
        REG_INV_WHEEL_BASE: cfg.inv_wheel_base <= cfg_data[23:0];
        REG_INIT_X: cfg.init_x <= cfg_data;
        REG_INIT_Y: cfg.init_y <= cfg_data;
        REG_INIT_HEADING: cfg.init_heading <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front end: accepts items and computes the wheel angle changes.
  ddo_front u_front (
    .clk    (clk),
    .rst    (rst),
    .items  (items),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_in)
  );

  // Decoupling queue.
  ddo_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .pop_item  (q_out)
  );

  // Back end: pose arithmetic and result register.
  ddo_back #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_avail (q_avail),
    .q_item  (q_out),
    .q_pop   (q_pop),
    .results (results)
  );

endmodule

// ===== sv/ddo_front.sv =====
module ddo_front
  import ddo_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  ddo_in_if.sink items,
  input  logic   q_full,
  output logic   q_push,
  output item_t  q_item
);

  logic signed [31:0] last_left;
  logic signed [31:0] last_right;

  // Accept a transaction whenever the queue has room.
  assign items.ready = !q_full;
  assign q_push = items.valid && !q_full;

  // Angle changes are taken at full width, with no wrap.
  always_comb begin
    q_item.cmd = items.cmd;
    q_item.delta_left = 33'(items.angle_left) - 33'(last_left);
    q_item.delta_right = 33'(items.angle_right) - 33'(last_right);
  end

  // Every accepted item, load or update, becomes the new reference angle.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_left <= '0;
      last_right <= '0;
    end else if (q_push) begin
      last_left <= items.angle_left;
      last_right <= items.angle_right;
    end
  end

endmodule

// ===== sv/ddo_queue.sv =====
module ddo_queue
  import ddo_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  avail,
  output item_t pop_item
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  item_t slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0] count;

  assign full = (count == (PW+1)'(QUEUE_DEPTH));
  assign avail = (count != '0);
  assign pop_item = slots[rd_ptr];

  // Storage is written at the tail only.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/ddo_back.sv =====
module ddo_back
  import ddo_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     q_avail,
  input  item_t    q_item,
  output logic     q_pop,
  ddo_out_if.source results
);

  // Pi rounded to FRAC_BITS fraction bits, and derived constants.
  localparam logic [63:0] PI_F = ((PI_Q62 >> (62 - FRAC_BITS - 1)) + 64'd1) >> 1;
  localparam logic [REM_W-1:0] TWO_PI_U = REM_W'(2 * PI_F);
  localparam logic signed [REM_W:0] PI_S = (REM_W+1)'(PI_F);
  localparam logic signed [REM_W:0] TWO_PI_S = (REM_W+1)'(2 * PI_F);
  localparam int ZSH = 30 - FRAC_BITS;

  // Reciprocal of two pi scaled by 2^MID_W, and the split of the heading
  // magnitude into a low and a high part for the quotient estimate.
  localparam int RW = 31;
  localparam logic [RW-1:0] RECIP = RW'((64'd1 << MID_W) / (2 * PI_F));
  localparam int DLW = (MID_W + 1) / 2;
  localparam int DHW = MID_W - DLW;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_DIV = 3'd3;
  localparam logic [2:0] S_FOLD = 3'd4;
  localparam logic [2:0] S_ROT = 3'd5;
  localparam logic [2:0] S_OUT = 3'd6;

  // Products run on the shared multiplier.
  localparam logic [2:0] OP_SL = 3'd0;
  localparam logic [2:0] OP_SR = 3'd1;
  localparam logic [2:0] OP_DPSI = 3'd2;
  localparam logic [2:0] OP_X = 3'd3;
  localparam logic [2:0] OP_Y = 3'd4;

  logic [2:0] state;
  logic [2:0] mop;
  logic [1:0] mph;
  logic [5:0] cnt;

  logic signed [32:0] dl;
  logic signed [32:0] dr;
  logic signed [33:0] sl;
  logic signed [33:0] sr;
  logic signed [43:0] dpsi;
  logic signed [31:0] step;
  logic signed [31:0] px;
  logic signed [31:0] py;
  logic signed [31:0] ph;
  logic [MID_W-1:0] mid_mag;
  logic mid_neg;
  logic [REM_W-1:0] rem;
  logic [DLW+RW-1:0] div_lo;
  logic [DHW+RW-1:0] div_hi;
  logic [RW-1:0] div_q;
  logic signed [CW-1:0] cx;
  logic signed [CW-1:0] cy;
  logic signed [CW-1:0] cz;
  logic flip;
  logic signed [53:0] prod;
  logic signed [69:0] acc;
  logic out_valid;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_h;
  logic signed [31:0] out_step;

  logic signed [35:0] mul_a;
  logic signed [CW-1:0] mul_b;
  logic signed [17:0] mul_chunk;
  logic signed [53:0] mul_p;
  logic signed [70:0] mul_sum;
  logic signed [70:0] r16;
  logic signed [70:0] r30;
  logic signed [MID_W-1:0] mid;
  logic [DLW-1:0] div_op;
  logic [DLW+RW-1:0] div_mul;
  logic [MID_W+RW-1:0] div_sum;
  logic [REM_W-1:0] qt;
  logic signed [REM_W:0] red;
  logic signed [REM_W:0] red_adj;
  logic signed [CW-1:0] z0;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [CW-1:0] x_nx;
  logic signed [CW-1:0] y_nx;
  logic signed [CW-1:0] z_nx;

  assign q_pop = (state == S_IDLE) && q_avail;

  assign results.valid = out_valid;
  assign results.pos_x = out_x;
  assign results.pos_y = out_y;
  assign results.heading = out_h;
  assign results.distance_step = out_step;

  // Operand selection for the shared multiplier; B is taken in two 17-bit halves.
  always_comb begin
    case (mop)
      OP_SL: begin
        mul_a = 36'(dl);
        mul_b = CW'(cfg.wheel_radius);
      end
      OP_SR: begin
        mul_a = 36'(dr);
        mul_b = CW'(cfg.wheel_radius);
      end
      OP_DPSI: begin
        mul_a = 36'(sr) - 36'(sl);
        mul_b = CW'(cfg.inv_wheel_base);
      end
      OP_X: begin
        mul_a = 36'(step);
        mul_b = cx;
      end
      OP_Y: begin
        mul_a = 36'(step);
        mul_b = cy;
      end
      default: begin
        mul_a = 36'(dl);
        mul_b = CW'(cfg.wheel_radius);
      end
    endcase
    mul_chunk = (mph == 2'd0) ? $signed({1'b0, mul_b[16:0]})
                              : $signed({mul_b[CW-1], mul_b[CW-1:17]});
    mul_p = 54'(mul_a) * 54'(mul_chunk);
    mul_sum = 71'(acc) + (71'(prod) <<< 17);
    r16 = (mul_sum + (71'sd1 <<< 15)) >>> 16;
    r30 = (mul_sum + (71'sd1 <<< 29)) >>> 30;
  end

  // Mid-step heading, and the reduction modulo two pi: a quotient estimate by
  // reciprocal multiplication, low part first, that is at most one short.
  always_comb begin
    mid = MID_W'(ph) + MID_W'(dpsi >>> 1);
    div_op = (cnt == 6'd0) ? mid_mag[DLW-1:0] : DLW'(mid_mag[MID_W-1:DLW]);
    div_mul = (DLW+RW)'(div_op) * (DLW+RW)'(RECIP);
    div_sum = {div_hi, {DLW{1'b0}}} + (MID_W+RW)'(div_lo);
    qt = div_q[REM_W-1:0] * TWO_PI_U;
  end

  // Reduction into [-pi, pi], scaled to Q2.30 for the CORDIC.
  always_comb begin
    red = mid_neg ? -$signed({1'b0, rem}) : $signed({1'b0, rem});
    if (red > PI_S) begin
      red_adj = red - TWO_PI_S;
    end else if (red < -PI_S) begin
      red_adj = red + TWO_PI_S;
    end else begin
      red_adj = red;
    end
    z0 = CW'(red_adj) <<< ZSH;
  end

  // One CORDIC rotation.
  always_comb begin
    xs = cx >>> cnt;
    ys = cy >>> cnt;
    if (!cz[CW-1]) begin
      x_nx = cx - ys;
      y_nx = cy + xs;
      z_nx = cz - atan_q30(cnt[4:0]);
    end else begin
      x_nx = cx + ys;
      y_nx = cy - xs;
      z_nx = cz + atan_q30(cnt[4:0]);
    end
  end

  // Control state of the sequencer and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mop <= OP_SL;
      mph <= '0;
      cnt <= '0;
      out_valid <= 1'b0;
      px <= '0;
      py <= '0;
      ph <= '0;
    end else begin
      if (out_valid && results.ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_avail) begin
            dl <= q_item.delta_left;
            dr <= q_item.delta_right;
            if (q_item.cmd == CMD_LOAD) begin
              px <= cfg.init_x;
              py <= cfg.init_y;
              ph <= cfg.init_heading;
              step <= '0;
              state <= S_OUT;
            end else begin
              mop <= OP_SL;
              mph <= '0;
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          case (mph)
            2'd0: begin
              prod <= mul_p;
              mph <= 2'd1;
            end
            2'd1: begin
              acc <= 70'(prod);
              prod <= mul_p;
              mph <= 2'd2;
            end
            default: begin
              mph <= 2'd0;
              case (mop)
                OP_SL: begin
                  sl <= r16[33:0];
                  mop <= OP_SR;
                end
                OP_SR: begin
                  sr <= r16[33:0];
                  mop <= OP_DPSI;
                end
                OP_DPSI: begin
                  dpsi <= r16[43:0];
                  state <= S_PREP;
                end
                OP_X: begin
                  px <= sat32(72'(px) + 72'($signed(r30[33:0])));
                  mop <= OP_Y;
                end
                default: begin
                  py <= sat32(72'(py) + 72'($signed(r30[33:0])));
                  state <= S_OUT;
                end
              endcase
            end
          endcase
        end
        S_PREP: begin
          mid_neg <= mid[MID_W-1];
          mid_mag <= mid[MID_W-1] ? MID_W'(-mid) : MID_W'(mid);
          ph <= sat32(72'(ph) + 72'(dpsi));
          step <= sat32(72'((36'(sr) + 36'(sl)) >>> 1));
          rem <= '0;
          cnt <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          // Low and high partial products, quotient, remainder, correction.
          case (cnt)
            6'd0: begin
              div_lo <= div_mul;
              cnt <= 6'd1;
            end
            6'd1: begin
              div_hi <= div_mul[DHW+RW-1:0];
              cnt <= 6'd2;
            end
            6'd2: begin
              div_q <= div_sum[MID_W+RW-1:MID_W];
              cnt <= 6'd3;
            end
            6'd3: begin
              rem <= mid_mag[REM_W-1:0] - qt;
              cnt <= 6'd4;
            end
            default: begin
              if (rem >= TWO_PI_U) begin
                rem <= rem - TWO_PI_U;
              end
              state <= S_FOLD;
            end
          endcase
        end
        S_FOLD: begin
          if (z0 > HALF_PI_Q30) begin
            cz <= z0 - PI_Q30;
            flip <= 1'b1;
          end else if (z0 < -HALF_PI_Q30) begin
            cz <= z0 + PI_Q30;
            flip <= 1'b1;
          end else begin
            cz <= z0;
            flip <= 1'b0;
          end
          cx <= GAIN_Q30;
          cy <= '0;
          cnt <= '0;
          state <= S_ROT;
        end
        S_ROT: begin
          cz <= z_nx;
          cnt <= cnt + 1'b1;
          if (cnt == 6'(CORDIC_STEPS - 1)) begin
            cx <= flip ? -x_nx : x_nx;
            cy <= flip ? -y_nx : y_nx;
            mop <= OP_X;
            mph <= '0;
            state <= S_MUL;
          end else begin
            cx <= x_nx;
            cy <= y_nx;
          end
        end
        S_OUT: begin
          if (!out_valid || results.ready) begin
            out_x <= px;
            out_y <= py;
            out_h <= ph;
            out_step <= step;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== tb/sv/tb_diff_drive_odometry.sv =====
`timescale 1ns / 1ps

module tb_diff_drive_odometry;
  import ddo_pkg::*;

  localparam int STEPS = CORDIC_STEPS_DEF;
  localparam int FRAC = FRAC_BITS_DEF;
  localparam longint Q30_PI = 64'sd3373259426;
  localparam longint Q30_HALF_PI = 64'sd1686629713;
  localparam longint Q30_GAIN = 64'sd652032874;
  localparam longint ATAN_Q30 [24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
    logic signed [31:0] distance_step;
  } pose_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  ddo_in_if in_ch ();
  ddo_out_if out_ch ();

  diff_drive_odometry dut (
    .clk(clk), .rst(rst), .items(in_ch.sink), .results(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state: configuration copy and pose.
  longint radius_q, inv_base_q, seed_x, seed_y, seed_hdg;
  longint cur_x, cur_y, cur_hdg, prev_left, prev_right;

  pose_t pose_q[$];
  int err_count = 0;
  int hold_cycles = 0;
  int hold_req_len = 0;
  int hold_req_id = 0;
  int hold_ack_id = 0;
  bit ready_steady = 0;
  int ang_l, ang_r;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint rnd_shift(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Cosine and sine in Q2.30 of a heading in Q16.16.
  function automatic void cos_sin(input longint ang, output longint c, output longint s);
    logic [63:0] pq;
    longint pi_f, two_pi, r, z, x, y, xs, ys;
    bit flip;
    pq = PI_Q62 >> (62 - FRAC - 1);
    pi_f = longint'((pq + 64'd1) >> 1);
    two_pi = 2 * pi_f;
    flip = 0;
    r = ang % two_pi;
    if (r > pi_f) r -= two_pi;
    if (r < -pi_f) r += two_pi;
    z = r * (64'sd1 <<< (30 - FRAC));
    if (z > Q30_HALF_PI) begin
      z -= Q30_PI;
      flip = 1;
    end else if (z < -Q30_HALF_PI) begin
      z += Q30_PI;
      flip = 1;
    end
    x = Q30_GAIN;
    y = 0;
    for (int i = 0; i < STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys;
        y += xs;
        z -= ATAN_Q30[i];
      end else begin
        x += ys;
        y -= xs;
        z += ATAN_Q30[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // Advances the predicted pose by one item and returns the expected result.
  function automatic pose_t advance_pose(logic cmd, logic signed [31:0] al,
                                         logic signed [31:0] ar);
    longint l, r, sl, sr, dpsi, mid, c, s, step;
    pose_t p;
    l = al;
    r = ar;
    step = 0;
    if (cmd == CMD_LOAD) begin
      cur_x = seed_x;
      cur_y = seed_y;
      cur_hdg = seed_hdg;
    end else begin
      sl = rnd_shift((l - prev_left) * radius_q, 16);
      sr = rnd_shift((r - prev_right) * radius_q, 16);
      dpsi = rnd_shift((sr - sl) * inv_base_q, 16);
      mid = cur_hdg + (dpsi >>> 1);
      step = clamp32((sr + sl) >>> 1);
      cos_sin(mid, c, s);
      cur_x = clamp32(cur_x + rnd_shift(step * c, 30));
      cur_y = clamp32(cur_y + rnd_shift(step * s, 30));
      cur_hdg = clamp32(cur_hdg + dpsi);
    end
    prev_left = l;
    prev_right = r;
    p.pos_x = cur_x[31:0];
    p.pos_y = cur_y[31:0];
    p.heading = cur_hdg[31:0];
    p.distance_step = step[31:0];
    return p;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %h, expected %h at %0t", field, got, want, $realtime);
    err_count++;
  endtask

  // Sends one item and records its expected result when it is accepted.
  task automatic send_item(logic cmd, logic signed [31:0] al, logic signed [31:0] ar);
    in_ch.valid = 1'b1;
    in_ch.cmd = cmd;
    in_ch.angle_left = al;
    in_ch.angle_right = ar;
    do @(posedge clk); while (!in_ch.ready);
    pose_q.push_back(advance_pose(cmd, al, ar));
    @(negedge clk);
  endtask

  task automatic idle_gap();
    int k, n;
    k = $urandom_range(0, 99);
    n = (k < 60) ? 0 : (k < 92) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    if (n > 0) begin
      in_ch.valid = 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (pose_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_WHEEL_RADIUS: radius_q = val[15:0];
      REG_INV_WHEEL_BASE: inv_base_q = val[23:0];
      REG_INIT_X: seed_x = longint'(signed'(val));
      REG_INIT_Y: seed_y = longint'(signed'(val));
      REG_INIT_HEADING: seed_hdg = longint'(signed'(val));
      default: ;
    endcase
  endtask

  task automatic write_all(logic [15:0] rad, logic [23:0] inv, logic [31:0] ix,
                           logic [31:0] iy, logic [31:0] ih);
    drain();
    write_reg(REG_WHEEL_RADIUS, {16'd0, rad});
    write_reg(REG_INV_WHEEL_BASE, {8'd0, inv});
    write_reg(REG_INIT_X, ix);
    write_reg(REG_INIT_Y, iy);
    write_reg(REG_INIT_HEADING, ih);
  endtask

  // Drives results.ready: random stalls, quiet stretches and long holds.
  // A requested long hold is picked up here and counted down in cycles.
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_req_id != hold_ack_id) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_req_len;
      hold_ack_id <= hold_req_id;
    end else if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (ready_steady) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) < 75);
      if ($urandom_range(0, 499) == 0) hold_cycles <= $urandom_range(20, 80);
    end
  end

  // Checks each result transaction against the oldest expectation.
  always @(posedge clk) begin
    pose_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pose_q.size() == 0) begin
        $display("unexpected result transaction at %0t", $realtime);
        err_count++;
      end else begin
        e = pose_q.pop_front();
        if (out_ch.pos_x !== e.pos_x) report("pos_x", out_ch.pos_x, e.pos_x);
        if (out_ch.pos_y !== e.pos_y) report("pos_y", out_ch.pos_y, e.pos_y);
        if (out_ch.heading !== e.heading) report("heading", out_ch.heading, e.heading);
        if (out_ch.distance_step !== e.distance_step)
          report("distance_step", out_ch.distance_step, e.distance_step);
      end
    end
  end

  // Extremes of angles and registers, loads and zero products.
  task automatic test_directed();
    send_item(CMD_UPDATE, 0, 0);
    send_item(CMD_UPDATE, 32'sh00010000, 32'sh00020000);
    send_item(CMD_LOAD, 32'sh7FFFFFFF, 32'sh80000000);
    send_item(CMD_UPDATE, 32'sh80000000, 32'sh7FFFFFFF);
    send_item(CMD_UPDATE, 32'sh7FFFFFFF, 32'sh80000000);
    write_all(16'hFFFF, 24'hFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    send_item(CMD_LOAD, 0, 0);
    send_item(CMD_UPDATE, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send_item(CMD_UPDATE, 32'sh80000000, 32'sh80000000);
    send_item(CMD_UPDATE, 32'sh80000000, 32'sh7FFFFFFF);
    send_item(CMD_UPDATE, 32'sh00001000, 32'sh00003000);
    write_all(16'd0, 24'd0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
    send_item(CMD_LOAD, 32'sh12345678, 32'sh87654321);
    send_item(CMD_UPDATE, 32'sh7FFFFFFF, 32'sh00000000);
    write_all(16'd1, 24'd1, 32'h0, 32'h0, 32'h00032000);
    send_item(CMD_LOAD, 0, 0);
    send_item(CMD_UPDATE, 32'sh00400000, 32'shFFC00000);
    write_all(16'd2621, 24'd327680, 32'h0, 32'h0, 32'hFFFCE000);
    send_item(CMD_LOAD, 0, 0);
    send_item(CMD_UPDATE, 32'sh00100000, 32'sh00200000);
    send_item(CMD_UPDATE, 32'sh00100000, 32'sh00080000);
    ang_l = 32'sh00100000;
    ang_r = 32'sh00080000;
  endtask

  // Random motion with a fresh setting per phase.
  task automatic test_random(int phases, int per_phase);
    int k;
    logic signed [31:0] al, ar;
    for (int p = 0; p < phases; p++) begin
      k = $urandom_range(0, 3);
      write_all((k == 0) ? 16'hFFFF : 16'($urandom_range(1, 65535)),
                (k == 1) ? 24'hFFFFFF : (k == 2) ? 24'($urandom_range(1, 3)) :
                                                    24'($urandom_range(1, 2000000)),
                $urandom, $urandom, $urandom);
      ready_steady = (p % 5 == 4);
      for (int i = 0; i < per_phase; i++) begin
        k = $urandom_range(0, 99);
        if (k < 8) begin
          al = $urandom;
          ar = $urandom;
          send_item(CMD_LOAD, al, ar);
        end else if (k < 18) begin
          al = $urandom;
          ar = $urandom;
          send_item(CMD_UPDATE, al, ar);
        end else begin
          al = ang_l + $signed($urandom_range(0, 400000)) - 200000;
          ar = ang_r + $signed($urandom_range(0, 400000)) - 200000;
          send_item(CMD_UPDATE, al, ar);
        end
        ang_l = al;
        ang_r = ar;
        if (!ready_steady) idle_gap();
      end
    end
    ready_steady = 0;
  endtask

  // Long receiver hold while items keep coming, so the input stalls.
  task automatic test_backpressure();
    drain();
    hold_req_len = 600;
    hold_req_id++;
    repeat (12) begin
      ang_l += 32'sd3000;
      ang_r += 32'sd5000;
      send_item(CMD_UPDATE, ang_l, ang_r);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_UPDATE;
    in_ch.angle_left = '0;
    in_ch.angle_right = '0;
    radius_q = 2621;
    inv_base_q = 327680;
    seed_x = 0;
    seed_y = 0;
    seed_hdg = 0;
    cur_x = 0;
    cur_y = 0;
    cur_hdg = 0;
    prev_left = 0;
    prev_right = 0;
    repeat (6) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);
    test_directed();
    test_backpressure();
    test_random(28, 50);
    test_backpressure();
    drain();
    repeat (100) @(negedge clk);
    if (err_count == 0 && pose_q.size() == 0) begin
      $display("diff_drive_odometry test passed");
    end else begin
      $display("diff_drive_odometry test failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("diff_drive_odometry test failed");
    $finish;
  end

endmodule

// ===== diff_drive_odometry.f =====
sv/ddo_pkg.sv
sv/ddo_in_if.sv
sv/ddo_out_if.sv
sv/ddo_front.sv
sv/ddo_queue.sv
sv/ddo_back.sv
sv/diff_drive_odometry.sv
tb/sv/tb_diff_drive_odometry.sv
